/* design/icfp_pkg.sv */
// Shared constants, types and helpers for the impedance command frame packer.
`timescale 1ns / 1ps

package icfp_pkg;

   // Code widths of the linear mapping.
   localparam int POSITION_CODE_BITS = 16;
   localparam int FIELD_CODE_BITS = 12;

   // Frame layout: one 16-bit position field and four 12-bit fields.
   localparam int POS_FIELD_W = 16;
   localparam int FIELD_W = 12;
   localparam int OUT_W = 32;
   localparam int FRAME_W = 2 * OUT_W;

   localparam int VALUE_W = 32;
   localparam int LIMIT_W = 31;
   localparam int DEN_W = LIMIT_W + 1;
   localparam int SUM_W = VALUE_W + 2;

   localparam int LANES = 5;
   localparam int LANE_POS = 0;
   localparam int LANE_SPEED = 1;
   localparam int LANE_STIFF = 2;
   localparam int LANE_DAMP = 3;
   localparam int LANE_TORQUE = 4;

   // Lanes clamped to -max..+max; the others are clamped to 0..max.
   localparam logic [LANES-1:0] LANE_SYMMETRIC = 5'b10011;

   localparam int DIV_STEPS = (POSITION_CODE_BITS > FIELD_CODE_BITS) ?
                              POSITION_CODE_BITS : FIELD_CODE_BITS;
   localparam int DIV_W = DEN_W + DIV_STEPS;

   // Offset add, clamp, numerator, then one stage per quotient bit.
   localparam int DEPTH = DIV_STEPS + 3;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [POS_FIELD_W-1:0] POS_CODE_MAX =
      POS_FIELD_W'((1 << POSITION_CODE_BITS) - 1);
   localparam logic [FIELD_W-1:0] FIELD_CODE_MAX =
      FIELD_W'((1 << FIELD_CODE_BITS) - 1);

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSITION_MAX  = 0,
      CSR_SPEED_MAX     = 1,
      CSR_TORQUE_MAX    = 2,
      CSR_STIFFNESS_MAX = 3,
      CSR_DAMPING_MAX   = 4,
      CSR_ZERO_OFFSET   = 5
   } csr_index_type;

   // Limit reset values in lane order.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET [LANES] = '{
      LIMIT_W'(819200),
      LIMIT_W'(1310720),
      LIMIT_W'(32768000),
      LIMIT_W'(327680),
      LIMIT_W'(1179648)
   };

   function automatic int lane_code_bits(input int lane);
      return (lane == LANE_POS) ? POSITION_CODE_BITS : FIELD_CODE_BITS;
   endfunction

endpackage

/* design/icfp_if.sv */
// Channel interfaces of the impedance command frame packer.
`timescale 1ns / 1ps

interface icfp_cmd_if import icfp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] target_position;
   logic signed [VALUE_W-1:0] target_speed;
   logic signed [VALUE_W-1:0] stiffness_gain;
   logic signed [VALUE_W-1:0] damping_gain;
   logic signed [VALUE_W-1:0] feed_torque;

   modport source (
      output valid, target_position, target_speed, stiffness_gain, damping_gain,
      output feed_torque,
      input  ready
   );
   modport sink (
      input  valid, target_position, target_speed, stiffness_gain, damping_gain,
      input  feed_torque,
      output ready
   );
endinterface

interface icfp_rsp_if import icfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   frame_bytes_0_to_3;
   logic [OUT_W-1:0]   frame_bytes_4_to_7;
   logic [LANES-1:0]   clamped_mask;

   modport source (
      output valid, frame_bytes_0_to_3, frame_bytes_4_to_7, clamped_mask,
      input  ready
   );
   modport sink (
      input  valid, frame_bytes_0_to_3, frame_bytes_4_to_7, clamped_mask,
      output ready
   );
endinterface

interface icfp_csr_if import icfp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VALUE_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/impedance_command_frame_packer.sv */
// Top level of the impedance command frame packer.
`timescale 1ns / 1ps

// Packs one impedance command per clock into an 8-byte frame unless rsp_if stalls
// with the pipeline full. A transaction on req_if is answered by exactly one
// transaction on rsp_if, in order, after DEPTH stages: one stage removes the zero
// offset and adds the lane limit, one clamps, one forms the numerator, and a restoring
// divider retires one quotient bit per stage over 16 stages. A stall on rsp_if
// only holds stages that are full, so bubbles close up and req_if keeps taking
// commands until the whole pipeline is occupied. The csr_if port always
// accepts; registers are meant to be written while no command is in flight,
// and an index beyond the register list is ignored. A limit of zero forces its
// code to zero.
module impedance_command_frame_packer
   import icfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   icfp_cmd_if.sink   req_if,
   icfp_rsp_if.source rsp_if,
   icfp_csr_if.sink   csr_if
);

   // Configuration registers.
   logic        [LIMIT_W-1:0] lim_ff [LANES];
   logic        [LIMIT_W-1:0] lim_in [LANES];
   logic signed [VALUE_W-1:0] zero_off_ff;
   logic signed [VALUE_W-1:0] zero_off_in;

   // Pipeline control.
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [DEPTH-1:0] go;

   // Stage payloads.
   logic signed [VALUE_W-1:0] val [LANES];
   logic signed [SUM_W-1:0]   a_ff [LANES];
   logic signed [SUM_W-1:0]   a_in [LANES];
   logic        [DEN_W-1:0]   den [LANES];
   logic        [LANES-1:0]   den_nz;
   logic        [DEN_W-1:0]   ac_ff [LANES];
   logic        [DEN_W-1:0]   ac_in [LANES];
   logic        [LANES-1:0]   hit_in;
   logic        [LANES-1:0]   hit_ff [1:DEPTH-1];
   logic        [DIV_W-1:0]   rem_ff [DIV_STEPS][LANES];
   logic        [DIV_W-1:0]   rem_in [DIV_STEPS][LANES];
   logic        [DIV_STEPS-1:0] quo_ff [1:DIV_STEPS][LANES];
   logic        [DIV_STEPS-1:0] quo_in [1:DIV_STEPS][LANES];
   logic        [LANES-1:0]   ge_step [DIV_STEPS];
   logic        [FRAME_W-1:0] frame;

   // ---------------------------------------------------------------- config
   assign csr_if.ready = 1'b1;

   always_comb begin
      lim_in = lim_ff;
      zero_off_in = zero_off_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_POSITION_MAX:  lim_in[LANE_POS] = csr_if.data[LIMIT_W-1:0];
            CSR_SPEED_MAX:     lim_in[LANE_SPEED] = csr_if.data[LIMIT_W-1:0];
            CSR_TORQUE_MAX:    lim_in[LANE_TORQUE] = csr_if.data[LIMIT_W-1:0];
            CSR_STIFFNESS_MAX: lim_in[LANE_STIFF] = csr_if.data[LIMIT_W-1:0];
            CSR_DAMPING_MAX:   lim_in[LANE_DAMP] = csr_if.data[LIMIT_W-1:0];
            CSR_ZERO_OFFSET:   zero_off_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIMIT_RESET;
         zero_off_ff <= '0;
      end else begin
         lim_ff <= lim_in;
         zero_off_ff <= zero_off_in;
      end
   end

   // ------------------------------------------------------- pipeline control
   // A stage may load when rsp_if is ready, or when it or some later stage has a bubble.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         go[i] = rsp_if.ready || ((~vld_ff >> i) != '0);
      end
      vld_in[0] = go[0] ? req_if.valid : vld_ff[0];
      for (int i = 1; i < DEPTH; i++) begin
         vld_in[i] = go[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_if.ready = go[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------ stages 0, 1 and 2
   // Symmetric lanes are shifted by +max so every lane clamps to 0..den.
   always_comb begin
      val[LANE_POS] = req_if.target_position;
      val[LANE_SPEED] = req_if.target_speed;
      val[LANE_STIFF] = req_if.stiffness_gain;
      val[LANE_DAMP] = req_if.damping_gain;
      val[LANE_TORQUE] = req_if.feed_torque;
      for (int l = 0; l < LANES; l++) begin
         a_in[l] = SUM_W'(val[l]);
         if (l == LANE_POS) begin
            a_in[l] = a_in[l] - SUM_W'(zero_off_ff);
         end
         if (LANE_SYMMETRIC[l]) begin
            a_in[l] = a_in[l] + SUM_W'(lim_ff[l]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         den[l] = LANE_SYMMETRIC[l] ? {lim_ff[l], 1'b0} : {1'b0, lim_ff[l]};
         den_nz[l] = (lim_ff[l] != '0);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (a_ff[l][SUM_W-1]) begin
            hit_in[l] = 1'b1;
            ac_in[l] = '0;
         end else if (a_ff[l][SUM_W-2:0] > (SUM_W-1)'(den[l])) begin
            hit_in[l] = 1'b1;
            ac_in[l] = den[l];
         end else begin
            hit_in[l] = 1'b0;
            ac_in[l] = a_ff[l][DEN_W-1:0];
         end
      end
   end

   // Numerator value * (2^bits - 1), built as a shift and a subtract.
   for (genvar l = 0; l < LANES; l++) begin : g_num
      assign rem_in[0][l] = (DIV_W'(ac_ff[l]) << lane_code_bits(l)) - DIV_W'(ac_ff[l]);
   end

   // -------------------------------------------------------- divider stages
   // Each stage decides one quotient bit by a trial subtract of den << shift.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam int SHIFT = DIV_STEPS - 1 - k;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DIV_W:0] diff;
         assign diff = {1'b0, rem_ff[k][l]} - {1'b0, (DIV_W'(den[l]) << SHIFT)};
         assign ge_step[k][l] = den_nz[l] && !diff[DIV_W];
         if (k < DIV_STEPS - 1) begin : g_rem
            assign rem_in[k+1][l] = ge_step[k][l] ? diff[DIV_W-1:0] : rem_ff[k][l];
         end
         if (k == 0) begin : g_first
            assign quo_in[1][l] = DIV_STEPS'(ge_step[0][l]);
         end else begin : g_next
            assign quo_in[k+1][l] = {quo_ff[k][l][DIV_STEPS-2:0], ge_step[k][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         a_ff <= a_in;
      end
      if (go[1]) begin
         ac_ff <= ac_in;
         hit_ff[1] <= hit_in;
      end
      for (int s = 2; s < DEPTH; s++) begin
         if (go[s]) begin
            hit_ff[s] <= hit_ff[s-1];
         end
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (go[2+k]) begin
            rem_ff[k] <= rem_in[k];
         end
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
         if (go[2+k]) begin
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   // ------------------------------------------------------------------ output
   assign frame = {POS_FIELD_W'(quo_ff[DIV_STEPS][LANE_POS]),
                   FIELD_W'(quo_ff[DIV_STEPS][LANE_SPEED]),
                   FIELD_W'(quo_ff[DIV_STEPS][LANE_STIFF]),
                   FIELD_W'(quo_ff[DIV_STEPS][LANE_DAMP]),
                   FIELD_W'(quo_ff[DIV_STEPS][LANE_TORQUE])};

   assign rsp_if.valid = vld_ff[DEPTH-1];
   assign rsp_if.frame_bytes_0_to_3 = frame[FRAME_W-1:OUT_W];
   assign rsp_if.frame_bytes_4_to_7 = frame[OUT_W-1:0];
   assign rsp_if.clamped_mask = hit_ff[DEPTH-1];

endmodule

/* design/icfp_checker.sv */
// Port-level assertions for the impedance command frame packer, bound to the top.
`timescale 1ns / 1ps

module icfp_checker
   import icfp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] frame_hi,
   input logic [OUT_W-1:0] frame_lo,
   input logic [LANES-1:0] clamped_mask
);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   // Transactions taken in but not yet delivered.
   always_comb begin
      cnt_in = cnt_ff + CNT_W'(req_valid && req_ready) - CNT_W'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !rsp_valid)
      else $error("result offered with no transaction in flight");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("more transactions in flight than pipeline stages");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_hi) && $stable(frame_lo)
         && $stable(clamped_mask))
      else $error("stalled result changed");

   // A clamped value sits on a range end, so its code is zero or all ones.
   a_clamp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (!clamped_mask[LANE_POS] || frame_hi[OUT_W-1 -: POS_FIELD_W] == '0
            || frame_hi[OUT_W-1 -: POS_FIELD_W] == POS_CODE_MAX)
         && (!clamped_mask[LANE_DAMP] || frame_lo[2*FIELD_W-1 -: FIELD_W] == '0
            || frame_lo[2*FIELD_W-1 -: FIELD_W] == FIELD_CODE_MAX))
      else $error("clamped value did not give an end-of-range code");

endmodule

bind impedance_command_frame_packer icfp_checker u_icfp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .frame_hi     (rsp_if.frame_bytes_0_to_3),
   .frame_lo     (rsp_if.frame_bytes_4_to_7),
   .clamped_mask (rsp_if.clamped_mask)
);

/* tb/tb_impedance_command_frame_packer.sv */
// Self-checking testbench that drives random and corner commands into the frame packer.
`timescale 1ns / 1ps

module tb_impedance_command_frame_packer;
   import icfp_pkg::*;

   typedef struct packed {
      logic signed [VALUE_W-1:0] position;
      logic signed [VALUE_W-1:0] speed;
      logic signed [VALUE_W-1:0] stiffness;
      logic signed [VALUE_W-1:0] damping;
      logic signed [VALUE_W-1:0] torque;
   } command_type;

   typedef struct packed {
      logic [OUT_W-1:0] bytes_0_to_3;
      logic [OUT_W-1:0] bytes_4_to_7;
      logic [LANES-1:0] clamped;
   } frame_type;

   localparam longint POS_ALL_ONES = (longint'(1) << POSITION_CODE_BITS) - 1;
   localparam longint FIELD_ALL_ONES = (longint'(1) << FIELD_CODE_BITS) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int LONG_HOLD_CYCLES = 8 * DEPTH;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS = 100;
   localparam int RANDOM_PHASES = 6;

   logic clock;
   logic reset;

   icfp_cmd_if req_if ();
   icfp_rsp_if rsp_if ();
   icfp_csr_if csr_if ();

   impedance_command_frame_packer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Shadow copy of the configuration registers.
   logic [LIMIT_W-1:0]        position_limit;
   logic [LIMIT_W-1:0]        speed_limit;
   logic [LIMIT_W-1:0]        torque_limit;
   logic [LIMIT_W-1:0]        stiffness_limit;
   logic [LIMIT_W-1:0]        damping_limit;
   logic signed [VALUE_W-1:0] position_offset;

   command_type pending_commands [$];
   frame_type   expected_frames [$];
   int          commands_queued;
   int          commands_taken;
   int          mismatches;
   int          idle_cycles;
   logic        req_taken;

   bit          sender_bursty;
   bit          rsp_stalls_on;
   int          burst_left;
   int          gap_left;
   int          hold_requests;
   int          holds_served;
   int          hold_left;
   logic [15:0] ready_pattern;
   int          pattern_left;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Clamp to -limit..+limit, then map linearly onto 0..all_ones with the fraction dropped.
   function automatic longint scale_symmetric(input longint x, input logic [LIMIT_W-1:0] limit,
                                              input longint all_ones, output logic hit);
      longint lim;
      lim = limit;
      hit = 1'b0;
      if (x > lim) begin
         x = lim;
         hit = 1'b1;
      end
      if (x < -lim) begin
         x = -lim;
         hit = 1'b1;
      end
      if (lim == 0) return 0;
      return ((x + lim) * all_ones) / (2 * lim);
   endfunction

   function automatic longint scale_gain(input longint x, input logic [LIMIT_W-1:0] limit,
                                         input longint all_ones, output logic hit);
      longint lim;
      lim = limit;
      hit = 1'b0;
      if (x > lim) begin
         x = lim;
         hit = 1'b1;
      end
      if (x < 0) begin
         x = 0;
         hit = 1'b1;
      end
      if (lim == 0) return 0;
      return (x * all_ones) / lim;
   endfunction

   function automatic frame_type pack_command(input command_type c);
      logic [LANES-1:0]   hits;
      longint             pos_code, speed_code, stiff_code, damp_code, torque_code;
      logic [FRAME_W-1:0] frame;
      // The offset is removed at 64 bits so the difference cannot wrap.
      pos_code = scale_symmetric(longint'(c.position) - longint'(position_offset),
                                 position_limit, POS_ALL_ONES, hits[LANE_POS]);
      speed_code = scale_symmetric(longint'(c.speed), speed_limit, FIELD_ALL_ONES,
                                   hits[LANE_SPEED]);
      stiff_code = scale_gain(longint'(c.stiffness), stiffness_limit, FIELD_ALL_ONES,
                              hits[LANE_STIFF]);
      damp_code = scale_gain(longint'(c.damping), damping_limit, FIELD_ALL_ONES,
                             hits[LANE_DAMP]);
      torque_code = scale_symmetric(longint'(c.torque), torque_limit, FIELD_ALL_ONES,
                                    hits[LANE_TORQUE]);
      frame = {pos_code[POS_FIELD_W-1:0], speed_code[FIELD_W-1:0], stiff_code[FIELD_W-1:0],
               damp_code[FIELD_W-1:0], torque_code[FIELD_W-1:0]};
      return {frame, hits};
   endfunction

   function automatic logic [VALUE_W-1:0] pick_symmetric(input logic [LIMIT_W-1:0] limit,
                                                         input logic [VALUE_W-1:0] centre);
      longint lim;
      lim = limit;
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return centre + 32'(longint'($urandom_range(32'(2 * lim), 0)) - lim);
         4: return centre + 32'(lim + longint'($urandom_range(2, 0)) - 1);
         5: return centre + 32'(-lim + longint'($urandom_range(2, 0)) - 1);
         6: return $urandom();
         7: begin
            case ($urandom_range(3, 0))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         8: return centre;
         default: return centre + 32'($urandom_range(255, 0)) - 32'd128;
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_gain(input logic [LIMIT_W-1:0] limit);
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return 32'($urandom_range(32'(limit), 0));
         4: return 32'(limit) + 32'($urandom_range(2, 0)) - 32'd1;
         5: return 32'($urandom_range(2, 0)) - 32'd1;
         6: return $urandom();
         7: return $urandom() | 32'h8000_0000;
         8: return ($urandom_range(1, 0) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'(limit);
      endcase
   endfunction

   // Limit register data; bit 31 is random because the register drops it.
   function automatic logic [VALUE_W-1:0] random_limit();
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(4, 0))
         0: lim = LIMIT_W'($urandom_range(4095, 1));
         1: lim = LIMIT_W'($urandom_range(100 << 16, 1 << 16));
         2: lim = LIMIT_W'($urandom_range(32'h7FFF_FFFF, 1));
         3: lim = '1;
         default: lim = 1;
      endcase
      return {1'($urandom_range(1, 0)), lim};
   endfunction

   task automatic queue_command(input logic [VALUE_W-1:0] position, input logic [VALUE_W-1:0] speed,
                                input logic [VALUE_W-1:0] stiffness,
                                input logic [VALUE_W-1:0] damping,
                                input logic [VALUE_W-1:0] torque);
      pending_commands.insert(pending_commands.size(),
                              {position, speed, stiffness, damping, torque});
      commands_queued++;
   endtask

   task automatic queue_random_command();
      queue_command(pick_symmetric(position_limit, position_offset),
                    pick_symmetric(speed_limit, 32'd0), pick_gain(stiffness_limit),
                    pick_gain(damping_limit), pick_symmetric(torque_limit, 32'd0));
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [VALUE_W-1:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = reg_index;
      csr_if.data = value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic write_all_limits(input logic [VALUE_W-1:0] value);
      for (int r = CSR_POSITION_MAX; r <= CSR_DAMPING_MAX; r++)
         csr_write(csr_index_type'(r), value);
   endtask

   // Counters only move at the rising edge, so checking them at the falling edge is race free.
   task automatic wait_idle();
      while (commands_taken != commands_queued || expected_frames.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input frame_type want,
                                  input frame_type seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t ns %s: expected %h %h %b, got %h %h %b", $realtime, what,
                  want.bytes_0_to_3, want.bytes_4_to_7, want.clamped,
                  seen.bytes_0_to_3, seen.bytes_4_to_7, seen.clamped);
   endtask

   always @(negedge clock) begin : command_driver
      command_type next_cmd;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.target_position <= '0;
         req_if.target_speed <= '0;
         req_if.stiffness_gain <= '0;
         req_if.damping_gain <= '0;
         req_if.feed_torque <= '0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_commands.size() != 0) begin
            next_cmd = pending_commands.pop_front();
            req_if.target_position <= next_cmd.position;
            req_if.target_speed <= next_cmd.speed;
            req_if.stiffness_gain <= next_cmd.stiffness;
            req_if.damping_gain <= next_cmd.damping;
            req_if.feed_torque <= next_cmd.torque;
            req_if.valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else if (sender_bursty) begin
               burst_left = $urandom_range(24, 0);
               gap_left = $urandom_range(6, 1);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : frame_receiver
      if (reset) begin
         rsp_if.ready <= 1'b0;
         holds_served = 0;
         hold_left = 0;
         pattern_left = 0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!rsp_stalls_on) begin
         rsp_if.ready <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern = ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom());
            pattern_left = 48;
         end
         pattern_left--;
         rsp_if.ready <= ready_pattern[4'(pattern_left % 16)];
      end
   end

   always @(posedge clock) begin : handshake_monitor
      frame_type   seen;
      frame_type   want;
      command_type taken;
      if (reset) begin
         position_limit <= 31'd819200;
         speed_limit <= 31'd1310720;
         torque_limit <= 31'd1179648;
         stiffness_limit <= 31'd32768000;
         damping_limit <= 31'd327680;
         position_offset <= '0;
         req_taken <= 1'b0;
         idle_cycles <= 0;
         commands_taken = 0;
         mismatches = 0;
      end else begin
         // Results are checked before new commands are predicted in the same edge.
         if (rsp_if.valid && rsp_if.ready) begin
            seen = {rsp_if.frame_bytes_0_to_3, rsp_if.frame_bytes_4_to_7, rsp_if.clamped_mask};
            if (expected_frames.size() == 0) begin
               report_mismatch("frame with nothing outstanding", '0, seen);
            end else begin
               want = expected_frames.pop_front();
               if (seen.bytes_0_to_3 !== want.bytes_0_to_3 ||
                   seen.bytes_4_to_7 !== want.bytes_4_to_7 ||
                   seen.clamped !== want.clamped)
                  report_mismatch("frame mismatch", want, seen);
            end
         end
         if (req_if.valid && req_if.ready) begin
            taken = {req_if.target_position, req_if.target_speed, req_if.stiffness_gain,
                     req_if.damping_gain, req_if.feed_torque};
            expected_frames.insert(expected_frames.size(), pack_command(taken));
            commands_taken++;
         end
         req_taken <= req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_POSITION_MAX: position_limit <= csr_if.data[LIMIT_W-1:0];
               CSR_SPEED_MAX: speed_limit <= csr_if.data[LIMIT_W-1:0];
               CSR_TORQUE_MAX: torque_limit <= csr_if.data[LIMIT_W-1:0];
               CSR_STIFFNESS_MAX: stiffness_limit <= csr_if.data[LIMIT_W-1:0];
               CSR_DAMPING_MAX: damping_limit <= csr_if.data[LIMIT_W-1:0];
               CSR_ZERO_OFFSET: position_offset <= csr_if.data;
               default: ;
            endcase
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      sender_bursty = 1'b1;
      rsp_stalls_on = 1'b1;
      commands_queued = 0;
      hold_requests = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset limits: extremes of every field, values exactly on and just past each limit.
      queue_command(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      queue_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_command(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(32'd819200, 32'd1310720, 32'd32768000, 32'd327680, 32'd1179648);
      queue_command(-32'sd819200, -32'sd1310720, 32'd0, 32'd0, -32'sd1179648);
      queue_command(32'd819201, 32'd1310721, 32'd32768001, 32'd327681, 32'd1179649);
      queue_command(-32'sd819201, -32'sd1310721, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -32'sd1179649);
      queue_command(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      wait_idle();

      // Widest limits written with bit 31 set, most negative offset, and writes to
      // unmapped indexes that must leave everything alone.
      write_all_limits(32'hFFFF_FFFF);
      csr_write(CSR_ZERO_OFFSET, 32'h8000_0000);
      csr_write(CSR_UNMAPPED_LO, 32'd0);
      csr_write(CSR_UNMAPPED_HI, 32'd0);
      queue_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_command(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
      queue_command(32'd0, 32'h8000_0001, 32'd0, 32'd1, 32'h8000_0000);
      wait_idle();

      csr_write(CSR_ZERO_OFFSET, 32'h7FFF_FFFF);
      queue_command(32'h8000_0000, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
      queue_command(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF, 32'd1);
      wait_idle();

      // A zero limit forces its code to zero and flags any nonzero input.
      write_all_limits(32'h8000_0000);
      queue_command(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
      queue_command(32'h7FFF_FFFE, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
      queue_command($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_all_limits(32'hFFFF_FFFF);
               csr_write(CSR_ZERO_OFFSET, 32'h7FFF_FFFF);
            end
            1: begin
               write_all_limits(32'd1);
               csr_write(CSR_ZERO_OFFSET, 32'h8000_0000);
            end
            default: begin
               for (int r = CSR_POSITION_MAX; r <= CSR_DAMPING_MAX; r++)
                  csr_write(csr_index_type'(r), random_limit());
               csr_write(CSR_ZERO_OFFSET, $urandom());
            end
         endcase
         sender_bursty = (phase != 2 && phase != 3);
         rsp_stalls_on = (phase != 2);
         repeat (PHASE_ITEMS) queue_random_command();
         // The receiver holds off long enough for the pipeline to fill and push back.
         if (phase == 3)
            hold_requests++;
         wait_idle();
      end

      repeat (DEPTH + 4) @(negedge clock);
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
